FILE: sv/pec_pkg.sv
// Types, character codes and status codes for the postfix expression evaluator.
// No dependencies; imported by pec_div, pec_ctrl, pec_dp and the core (not by pec_ram).
`default_nettype none

package pec_pkg;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIV0    = 3'd1;
    localparam logic [2:0] ST_BADCHAR = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIVW,
        S_WB,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       set_err;
        logic [2:0] err_code;
        logic       arith;
        logic       div_start;
        logic       wb;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic err_latched;
        logic is_digit;
        logic is_space;
        logic is_op;
        logic is_div;
        logic full;
        logic lt_two;
        logic rhs_zero;
        logic div_done;
        logic div_busy;
        logic last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/pec_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/pec_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on pec_pkg.
`default_nettype none

module pec_div
    import pec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_quo;
    logic [31:0]      r_den;
    logic             r_neg;

    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic [31:0] w_abs_n;
    logic [31:0] w_abs_d;

    assign w_abs_n = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign w_abs_d = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;
    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor magnitude, so 32 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_n;
            r_den <= w_abs_d;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

`default_nettype wire

FILE: sv/pec_ctrl.sv
// Controller state machine: sequences decode, arithmetic, write-back and result.
// Depends on pec_pkg.
`default_nettype none

module pec_ctrl
    import pec_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_sts.last ? S_EMIT : S_IDLE;
                if (i_sts.err_latched || i_sts.is_space) begin
                    // nothing to do
                end else if (i_sts.is_digit) begin
                    if (i_sts.full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_OVER;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (!i_sts.is_op) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_BADCHAR;
                end else if (i_sts.lt_two) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_UNDER;
                end else if (i_sts.is_div && i_sts.rhs_zero) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_DIV0;
                end else if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end else begin
                    o_cmd.arith = 1'b1;
                    n_state     = S_WB;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/pec_dp.sv
// Datapath: character register, operand stack (RAM plus top-of-stack register),
// ALU, divider, error latch and result register. Depends on pec_pkg, pec_ram, pec_div.
`default_nettype none

module pec_dp
    import pec_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out      o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    logic [7:0]    r_char;
    logic          r_last;
    logic [CW-1:0] r_count;
    logic [31:0]   r_tos;
    logic [31:0]   r_res;
    logic [2:0]    r_err;
    logic          r_out_valid;
    t_out          r_out_data;

    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic [31:0]   w_lhs;
    logic [31:0]   w_digit;
    logic [31:0]   w_prod;
    logic [31:0]   w_quo;
    logic          w_div_busy;
    logic          w_div_done;
    logic          w_is_div;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_digit  = {24'd0, r_char - CH_0};
    assign w_prod   = w_lhs * r_tos;
    assign w_is_div = (r_char == CH_SLASH);

    pec_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push && (r_count != '0)),
        .i_waddr (w_cnt_m1[AW-1:0]),
        .i_wdata (r_tos),
        .i_raddr (w_cnt_m2[AW-1:0]),
        .o_rdata (w_lhs)
    );

    pec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_lhs),
        .i_divisor  (r_tos),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.wb) begin
                r_count <= w_cnt_m1;
            end else if (i_cmd.emit) begin
                r_count <= '0;
            end
            if (i_cmd.emit) begin
                r_err <= ST_OK;
            end else if (i_cmd.set_err && (r_err == ST_OK)) begin
                r_err <= i_cmd.err_code;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_in_data.char_code;
            r_last <= i_in_data.last_char;
        end
        if (i_cmd.push) begin
            r_tos <= w_digit;
        end else if (i_cmd.wb) begin
            r_tos <= w_is_div ? w_quo : r_res;
        end
        if (i_cmd.arith) begin
            case (r_char)
                CH_PLUS:  r_res <= w_lhs + r_tos;
                CH_MINUS: r_res <= w_lhs - r_tos;
                default:  r_res <= w_prod;
            endcase
        end
        if (i_cmd.emit) begin
            if (r_err != ST_OK) begin
                r_out_data.status <= r_err;
                r_out_data.value  <= '0;
            end else if (r_count == '0) begin
                r_out_data.status <= ST_UNDER;
                r_out_data.value  <= '0;
            end else begin
                r_out_data.status <= ST_OK;
                r_out_data.value  <= r_tos;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.err_latched = (r_err != ST_OK);
        o_sts.is_digit    = r_char inside {[CH_0:CH_9]};
        o_sts.is_space    = (r_char == CH_SPACE);
        o_sts.is_op       = r_char inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        o_sts.is_div      = w_is_div;
        o_sts.full        = (r_count >= FULL_CNT);
        o_sts.lt_two      = (r_count < CW'(2));
        o_sts.rhs_zero    = (r_tos == '0);
        o_sts.div_done    = w_div_done;
        o_sts.div_busy    = w_div_busy;
        o_sts.last        = r_last;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: sv/postfix_expression_evaluator_core.sv
// Postfix expression evaluator: one character per transfer, one result per expression.
// A digit, a space, an invalid character, an operator that only latches an error, or
// any character after an error is loaded and decoded before the next transfer is taken;
// + - * add a write-back; / also waits for the one-bit-per-cycle 32-bit divider (decode,
// 32 steps, done, write-back). The character marked last adds an emit state to load the
// result register, which holds the result until it is taken while the next
// expression's characters are already accepted; a last character that finds the
// register still full waits until it is taken.
// Stack entries sit in a RAM of STACK_DEPTH words behind a top-of-stack register.
// Depends on pec_pkg, pec_ram, pec_div, pec_ctrl, pec_dp.
`default_nettype none

module postfix_expression_evaluator_core
    import pec_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    pec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    pec_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.value == '0)
        else $error("non-ok result with non-zero value");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !w_sts.full)
        else $error("push on full stack");

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.div_busy)
        else $error("transfer accepted while divider busy");
`endif

endmodule

`default_nettype wire
